// ===== rtl/core/steq_pkg.sv =====
`default_nettype none

package steq_pkg;

  localparam int ID_W     = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;

  // operation codes on func
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                none_due;
    logic                last;
  } res_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/steq_slot_ram.sv =====
`default_nettype none

module steq_slot_ram
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TIME_BITS    = 48,
  parameter int PAYLOAD_BITS = 32,
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [TIME_BITS-1:0]    wr_time,
  input  wire logic [ID_W-1:0]         wr_id,
  input  wire logic [PAYLOAD_BITS-1:0] wr_pay,
  input  wire logic [IDX_W-1:0]        rd_addr,
  output logic      [TIME_BITS-1:0]    rd_time,
  output logic      [ID_W-1:0]         rd_id,
  output logic      [PAYLOAD_BITS-1:0] rd_pay
);

  localparam int WORD_W = TIME_BITS + ID_W + PAYLOAD_BITS;

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_time, wr_id, wr_pay};
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

  assign rd_time = rd_word[WORD_W-1 -: TIME_BITS];
  assign rd_id   = rd_word[PAYLOAD_BITS +: ID_W];
  assign rd_pay  = rd_word[PAYLOAD_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/steq_ctrl.sv =====
`default_nettype none

module steq_ctrl
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TIME_BITS    = 48,
  parameter int PAYLOAD_BITS = 32,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic [ID_W-1:0]         entry_id,
  input  wire logic [TIME_BITS-1:0]    due_time,
  input  wire logic [PAYLOAD_BITS-1:0] payload_tag,
  input  wire logic [TIME_BITS-1:0]    now_time,
  input  wire logic                    out_free,
  output logic                         push,
  output res_ctrl_t                    res_ctrl,
  output logic      [ID_W-1:0]         res_id,
  output logic      [TIME_BITS-1:0]    res_time,
  output logic      [PAYLOAD_BITS-1:0] res_pay,
  output logic      [CNT_W-1:0]        occ,
  output logic      [IDX_W-1:0]        rd_addr,
  input  wire logic [TIME_BITS-1:0]    rd_time,
  input  wire logic [ID_W-1:0]         rd_id,
  input  wire logic [PAYLOAD_BITS-1:0] rd_pay,
  output logic                         wr_en,
  output logic      [IDX_W-1:0]        wr_addr,
  output logic      [TIME_BITS-1:0]    wr_time,
  output logic      [ID_W-1:0]         wr_id,
  output logic      [PAYLOAD_BITS-1:0] wr_pay
);

  localparam int SUM_W = CNT_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_RM_RD   = 4'd3;
  localparam logic [3:0] S_RM_CHK  = 4'd4;
  localparam logic [3:0] S_SH_RD   = 4'd5;
  localparam logic [3:0] S_SH_WR   = 4'd6;
  localparam logic [3:0] S_TK_RD   = 4'd7;
  localparam logic [3:0] S_TK_CHK  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);
  localparam logic [CNT_W-1:0] ZERO       = '0;

  logic [3:0]              state;
  logic [3:0]              ret_state;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;
  logic                    hold_v;
  logic [FUNC_W-1:0]       op_r;
  logic [ID_W-1:0]         id_r;
  logic [TIME_BITS-1:0]    due_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [TIME_BITS-1:0]    now_r;

  logic [CNT_W-1:0]        rd_idx;
  logic [TIME_BITS-1:0]    cmp_a;
  logic [TIME_BITS-1:0]    cmp_b;
  logic                    lt;
  logic                    id_hit;

  // logical position to ring slot, head plus offset wrapped once
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // one shared comparator: insert asks due < slot, tick asks slot < now
  assign cmp_a  = (op_r == FUNC_INSERT) ? due_r : rd_time;
  assign cmp_b  = (op_r == FUNC_INSERT) ? rd_time : now_r;
  assign lt     = cmp_a < cmp_b;
  assign id_hit = rd_id == id_r;

  assign in_stall = state != S_IDLE;
  assign push     = (state == S_EMIT) && out_free;
  assign occ      = count;

  always_comb begin
    case (state)
      S_INS_RD: rd_idx = idx - ONE;
      S_SH_RD:  rd_idx = idx + ONE;
      S_TK_RD:  rd_idx = ZERO;
      default:  rd_idx = idx;
    endcase
  end

  assign rd_addr = phys(head, rd_idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head, idx);
    wr_time = due_r;
    wr_id   = id_r;
    wr_pay  = pay_r;
    case (state)
      S_INS_RD: begin
        wr_en = idx == ZERO;
      end
      S_INS_CHK: begin
        wr_en = 1'b1;
        if (lt) begin
          wr_time = rd_time;
          wr_id   = rd_id;
          wr_pay  = rd_pay;
        end
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_time = rd_time;
        wr_id   = rd_id;
        wr_pay  = rd_pay;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      hold_v    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= func;
            id_r  <= entry_id;
            due_r <= due_time;
            pay_r <= payload_tag;
            now_r <= now_time;
            res_ctrl  <= '{status: ST_INSERTED, none_due: 1'b0, last: 1'b1};
            res_id    <= '0;
            res_time  <= '0;
            res_pay   <= '0;
            ret_state <= S_IDLE;
            case (func)
              FUNC_INSERT: begin
                idx <= count;
                if (count == FULL_COUNT) begin
                  res_ctrl.status <= ST_FULL;
                  state           <= S_EMIT;
                end else begin
                  state <= S_INS_RD;
                end
              end
              FUNC_REMOVE: begin
                idx   <= '0;
                state <= S_RM_RD;
              end
              FUNC_TICK: begin
                hold_v <= 1'b0;
                state  <= S_TK_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx == ZERO) begin
            count <= count + ONE;
            state <= S_EMIT;
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (lt) begin
            idx   <= idx - ONE;
            state <= S_INS_RD;
          end else begin
            count <= count + ONE;
            state <= S_EMIT;
          end
        end
        S_RM_RD: begin
          if (idx == count) begin
            res_ctrl.status <= ST_NOT_FOUND;
            state           <= S_EMIT;
          end else begin
            state <= S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          if (id_hit) begin
            state <= S_SH_RD;
          end else begin
            idx   <= idx + ONE;
            state <= S_RM_RD;
          end
        end
        S_SH_RD: begin
          if (idx + ONE == count) begin
            count           <= count - ONE;
            res_ctrl.status <= ST_REMOVED;
            state           <= S_EMIT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx   <= idx + ONE;
          state <= S_SH_RD;
        end
        S_TK_RD: begin
          if (count == ZERO) begin
            res_ctrl  <= '{status: ST_FIRED, none_due: !hold_v, last: 1'b1};
            hold_v    <= 1'b0;
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            state <= S_TK_CHK;
          end
        end
        S_TK_CHK: begin
          if (lt && hold_v) begin
            // another entry is due, so the held one is not the final beat
            res_ctrl.last <= 1'b0;
            hold_v        <= 1'b0;
            ret_state     <= S_TK_RD;
            state         <= S_EMIT;
          end else if (lt) begin
            res_ctrl <= '{status: ST_FIRED, none_due: 1'b0, last: 1'b0};
            res_id   <= rd_id;
            res_time <= rd_time;
            res_pay  <= rd_pay;
            hold_v   <= 1'b1;
            head     <= phys(head, ONE);
            count    <= count - ONE;
            state    <= S_TK_RD;
          end else begin
            res_ctrl  <= '{status: ST_FIRED, none_due: !hold_v, last: 1'b1};
            hold_v    <= 1'b0;
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= ret_state;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_timer_event_queue_core.sv =====
// Timer event queue holding up to QUEUE_DEPTH entries (due time, id, payload
// tag) in a ring of slots kept in due-time order; ties keep arrival order.
// One item is worked at a time and in_stall stays high until its last result
// beat has been handed to the output register. Every slot visit passes through
// a read state and then a check or write state, as the single slot RAM has a
// registered read port and the one time comparator checks one slot per visit:
// an insert shifts the entries after the new one up by one slot, a remove
// searches then shifts down, a full table rejects an insert without a slot
// visit, and a tick fires due entries from the head, or gives one none_due beat
// when nothing is due. Every result beat may wait on out_stall. Slots are not
// cleared after reset and the block is ready at once; only data read from
// slots below the current occupancy is ever used.
`default_nettype none

module sorted_timer_event_queue_core
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TIME_BITS    = 48,
  parameter int PAYLOAD_BITS = 32,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic [ID_W-1:0]         entry_id,
  input  wire logic [TIME_BITS-1:0]    due_time,
  input  wire logic [PAYLOAD_BITS-1:0] payload_tag,
  input  wire logic [TIME_BITS-1:0]    now_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [STATUS_W-1:0]     status,
  output logic      [ID_W-1:0]         fired_id,
  output logic      [TIME_BITS-1:0]    fired_time,
  output logic      [PAYLOAD_BITS-1:0] fired_payload,
  output logic                         none_due,
  output logic      [CNT_W-1:0]        occupancy,
  output logic                         last
);

  logic                    out_free;
  logic                    push;
  res_ctrl_t               res_ctrl;
  logic [ID_W-1:0]         res_id;
  logic [TIME_BITS-1:0]    res_time;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [CNT_W-1:0]        occ;

  logic [IDX_W-1:0]        rd_addr;
  logic [TIME_BITS-1:0]    rd_time;
  logic [ID_W-1:0]         rd_id;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [TIME_BITS-1:0]    wr_time;
  logic [ID_W-1:0]         wr_id;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  assign out_free = !out_valid || !out_stall;

  steq_slot_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_time(wr_time),
    .wr_id  (wr_id),
    .wr_pay (wr_pay),
    .rd_addr(rd_addr),
    .rd_time(rd_time),
    .rd_id  (rd_id),
    .rd_pay (rd_pay)
  );

  steq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .entry_id   (entry_id),
    .due_time   (due_time),
    .payload_tag(payload_tag),
    .now_time   (now_time),
    .out_free   (out_free),
    .push       (push),
    .res_ctrl   (res_ctrl),
    .res_id     (res_id),
    .res_time   (res_time),
    .res_pay    (res_pay),
    .occ        (occ),
    .rd_addr    (rd_addr),
    .rd_time    (rd_time),
    .rd_id      (rd_id),
    .rd_pay     (rd_pay),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_time    (wr_time),
    .wr_id      (wr_id),
    .wr_pay     (wr_pay)
  );

  // output register, loaded only when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status        <= res_ctrl.status;
      none_due      <= res_ctrl.none_due;
      last          <= res_ctrl.last;
      fired_id      <= res_id;
      fired_time    <= res_time;
      fired_payload <= res_pay;
      occupancy     <= occ;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/steq_checker.sv =====
`default_nettype none

module steq_checker
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TIME_BITS    = 48,
  parameter int PAYLOAD_BITS = 32,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic [FUNC_W-1:0]       func,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [STATUS_W-1:0]     status,
  input wire logic [ID_W-1:0]         fired_id,
  input wire logic [TIME_BITS-1:0]    fired_time,
  input wire logic [PAYLOAD_BITS-1:0] fired_payload,
  input wire logic                    none_due,
  input wire logic [CNT_W-1:0]        occupancy,
  input wire logic                    last
);

  // a held result beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(fired_id)
      && $stable(fired_time) && $stable(fired_payload) && $stable(last))
    else $error("result beat changed while stalled");

  // a real operation keeps the input side busy on the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall
      && (func == FUNC_INSERT || func == FUNC_REMOVE || func == FUNC_TICK)
      |=> in_stall)
    else $error("input taken again straight after an operation");

  a_none_due: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_due |-> last && status == ST_FIRED && fired_id == '0
      && fired_time == '0 && fired_payload == '0)
    else $error("empty tick result malformed");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FIRED |-> last && !none_due && fired_id == '0)
    else $error("insert or remove result malformed");

  a_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond table depth");

endmodule

bind sorted_timer_event_queue_core steq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .TIME_BITS   (TIME_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_steq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .func         (func),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .fired_id     (fired_id),
  .fired_time   (fired_time),
  .fired_payload(fired_payload),
  .none_due     (none_due),
  .occupancy    (occupancy),
  .last         (last)
);

`default_nettype wire
